FILE: hw/rtl/rtsm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, sequencer states and divider request/response types
// for the ride time and mode share tracker. No dependencies.

package rtsm_pkg;

    localparam int TIME_W     = 32;
    localparam int STAMP_W    = (TIME_W < 32) ? TIME_W : 32;
    localparam bit STAMP_WIDE = (TIME_W > 32);

    localparam int MOV_W   = 32;
    localparam int MODE_N  = 3;
    localparam int PCT_W   = 7;
    localparam int NUM_W   = MOV_W + PCT_W;
    localparam int CNT_W   = $clog2(NUM_W + 1);
    localparam int MIN_W   = 17;
    localparam int TRIP_W  = 17;
    localparam int SPEED_W = 8;
    localparam int MODE_W  = 3;
    localparam int STEP_W  = 16;
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;

    localparam logic [MOV_W-1:0]   MS_PER_MINUTE  = 32'd60000;
    localparam logic [PCT_W-1:0]   FULL_PERCENT   = 7'd100;
    localparam logic [STEP_W-1:0]  MAX_STEP_RESET = 16'd2000;
    localparam logic [PADDR_W-1:0] ADDR_MAX_STEP  = 2'd0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MIN_GO,
        S_MIN_WAIT,
        S_ECO_GO,
        S_ECO_WAIT,
        S_NORM_GO,
        S_NORM_WAIT,
        S_SPORT,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [MOV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: hw/rtl/rtsm_div.sv
`timescale 1ns / 1ps
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on rtsm_pkg for widths and the request/response types.

module rtsm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  rtsm_pkg::div_req_t req,
    output rtsm_pkg::div_rsp_t rsp
);

    logic [rtsm_pkg::MOV_W-1:0] rem_reg, rem_next;
    logic [rtsm_pkg::MOV_W-1:0] dsr_reg, dsr_next;
    logic [rtsm_pkg::NUM_W-1:0] quo_reg, quo_next;
    logic [rtsm_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [rtsm_pkg::MOV_W:0]   rem_sh;
    logic [rtsm_pkg::MOV_W:0]   diff;

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[rtsm_pkg::NUM_W-1]};
        diff      = rem_sh - {1'b0, dsr_reg};
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            dsr_next  = req.divisor;
            quo_next  = req.dividend;
            cnt_next  = rtsm_pkg::CNT_W'(rtsm_pkg::NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[rtsm_pkg::MOV_W])
            begin
                rem_next = diff[rtsm_pkg::MOV_W-1:0];
                quo_next = {quo_reg[rtsm_pkg::NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[rtsm_pkg::MOV_W-1:0];
                quo_next = {quo_reg[rtsm_pkg::NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == rtsm_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: hw/rtl/rtsm_cfg.sv
`timescale 1ns / 1ps
// APB-style register port holding the largest counted time step.
// Depends on rtsm_pkg for widths, the register address and its reset value.

module rtsm_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rtsm_pkg::PADDR_W-1:0]  paddr,
    input  logic [rtsm_pkg::PDATA_W-1:0]  pwdata,
    output logic [rtsm_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output logic [rtsm_pkg::STEP_W-1:0]   max_step
);

    logic [rtsm_pkg::STEP_W-1:0] max_step_reg, max_step_next;
    logic                        hit;

    always_comb
    begin
        hit           = (paddr == rtsm_pkg::ADDR_MAX_STEP);
        max_step_next = max_step_reg;
        if (psel && penable && pwrite && hit)
        begin
            max_step_next = pwdata[rtsm_pkg::STEP_W-1:0];
        end
        prdata = hit ? rtsm_pkg::PDATA_W'(max_step_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_step_reg <= rtsm_pkg::MAX_STEP_RESET;
        end
        else
        begin
            max_step_reg <= max_step_next;
        end
    end

    assign pready   = 1'b1;
    assign max_step = max_step_reg;

endmodule

FILE: hw/rtl/ride_time_mode_share_tracker.sv
`timescale 1ns / 1ps
// Top level of the ride time and mode share tracker: totals, sequencer, result register.
// Depends on rtsm_pkg, rtsm_div and rtsm_cfg.
//
//   Channel   Handshake                   Word
//   config    psel/penable/pwrite/pready  paddr, pwdata, prdata (max_step_ms)
//   sample    in_valid/in_ready           now_ms, trip_tenths_km, speed_kmh, charge_percent, mode
//   result    out_valid/out_ready         ride_minutes ... sport_share, recorded, published
//
// A sample that only repeats the held results skips the divider and goes to the result register.
// A refresh with moving time makes three passes of the shared
// one-bit-per-cycle divider (39 steps each) for minutes, eco share and normal share.
// Reset clears all totals and held results and loads max_step_ms with 2000.
// in_ready is high only while the sequencer is idle; a finished word waits in the result
// register, and a new sample is taken meanwhile but its word is held until that one leaves.

module ride_time_mode_share_tracker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rtsm_pkg::PADDR_W-1:0]  paddr,
    input  logic [rtsm_pkg::PDATA_W-1:0]  pwdata,
    output logic [rtsm_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [31:0]                   now_ms,
    input  logic [rtsm_pkg::TRIP_W-1:0]   trip_tenths_km,
    input  logic [rtsm_pkg::SPEED_W-1:0]  speed_kmh,
    input  logic [rtsm_pkg::PCT_W-1:0]    charge_percent,
    input  logic [rtsm_pkg::MODE_W-1:0]   mode,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rtsm_pkg::MIN_W-1:0]    ride_minutes,
    output logic [rtsm_pkg::PCT_W-1:0]    charge_used,
    output logic [rtsm_pkg::PCT_W-1:0]    eco_share,
    output logic [rtsm_pkg::PCT_W-1:0]    normal_share,
    output logic [rtsm_pkg::PCT_W-1:0]    sport_share,
    output logic                          recorded,
    output logic                          published
);

    function automatic logic [rtsm_pkg::MOV_W-1:0] sat_add(
        input logic [rtsm_pkg::MOV_W-1:0]   a,
        input logic [rtsm_pkg::STAMP_W-1:0] b
    );
        logic [rtsm_pkg::MOV_W:0] sum;
        sum = (rtsm_pkg::MOV_W + 1)'(a) + (rtsm_pkg::MOV_W + 1)'(b);
        return sum[rtsm_pkg::MOV_W] ? '1 : sum[rtsm_pkg::MOV_W-1:0];
    endfunction

    rtsm_pkg::seq_state_t state_reg, state_next;
    rtsm_pkg::div_req_t   div_req;
    rtsm_pkg::div_rsp_t   div_rsp;

    logic [rtsm_pkg::STEP_W-1:0]  max_step;

    logic [rtsm_pkg::STAMP_W-1:0] last_stamp_reg, last_stamp_next;
    logic [rtsm_pkg::TRIP_W-1:0]  last_trip_reg, last_trip_next;
    logic [rtsm_pkg::MOV_W-1:0]   mv_reg, mv_next;
    logic [rtsm_pkg::MOV_W-1:0]   mt_reg [rtsm_pkg::MODE_N];
    logic [rtsm_pkg::MOV_W-1:0]   mt_next [rtsm_pkg::MODE_N];
    logic                         scv_reg, scv_next;
    logic [rtsm_pkg::PCT_W-1:0]   sc_reg, sc_next;
    logic [rtsm_pkg::MIN_W-1:0]   hmin_reg, hmin_next;
    logic [rtsm_pkg::PCT_W-1:0]   hchg_reg, hchg_next;
    logic [rtsm_pkg::PCT_W-1:0]   hsh_reg [rtsm_pkg::MODE_N];
    logic [rtsm_pkg::PCT_W-1:0]   hsh_next [rtsm_pkg::MODE_N];
    logic                         hrec_reg, hrec_next;
    logic                         pub_reg, pub_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         load_out;

    logic [rtsm_pkg::MIN_W-1:0]   o_min_reg;
    logic [rtsm_pkg::PCT_W-1:0]   o_chg_reg, o_eco_reg, o_norm_reg, o_sport_reg;
    logic                         o_rec_reg, o_pub_reg;

    logic                         cleared;
    logic [rtsm_pkg::STAMP_W:0]   stamp_diff;
    logic [rtsm_pkg::STAMP_W-1:0] step;
    logic                         step_ok;
    logic                         moving;
    logic [rtsm_pkg::MOV_W-1:0]   base_mv;
    logic                         base_scv;
    logic [rtsm_pkg::PCT_W-1:0]   base_sc;
    logic [rtsm_pkg::PCT_W:0]     share_sum;
    logic [rtsm_pkg::NUM_W-1:0]   half_mv;

    rtsm_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .max_step (max_step)
    );

    rtsm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        cleared    = trip_tenths_km < last_trip_reg;
        stamp_diff = {1'b0, now_ms[rtsm_pkg::STAMP_W-1:0]} - {1'b0, last_stamp_reg};
        step       = stamp_diff[rtsm_pkg::STAMP_W-1:0];
        step_ok    = (step != '0) && (step <= rtsm_pkg::STAMP_W'(max_step))
                     && !(rtsm_pkg::STAMP_WIDE && stamp_diff[rtsm_pkg::STAMP_W]);
        moving     = step_ok && (speed_kmh != '0);
        base_mv    = cleared ? '0 : mv_reg;
        base_scv   = cleared ? 1'b0 : scv_reg;
        base_sc    = cleared ? '0 : sc_reg;
        half_mv    = rtsm_pkg::NUM_W'(mv_reg >> 1);
        share_sum  = {1'b0, hsh_reg[0]} + {1'b0, hsh_reg[1]};

        state_next      = state_reg;
        last_stamp_next = last_stamp_reg;
        last_trip_next  = last_trip_reg;
        mv_next         = mv_reg;
        scv_next        = scv_reg;
        sc_next         = sc_reg;
        hmin_next       = hmin_reg;
        hchg_next       = hchg_reg;
        hrec_next       = hrec_reg;
        pub_next        = pub_reg;
        for (int i = 0; i < rtsm_pkg::MODE_N; i++)
        begin
            mt_next[i]  = mt_reg[i];
            hsh_next[i] = hsh_reg[i];
        end
        out_valid_next   = out_valid_reg && !out_ready;
        load_out         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = rtsm_pkg::NUM_W'(mv_reg);
        div_req.divisor  = rtsm_pkg::MS_PER_MINUTE;

        case (state_reg)
            rtsm_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    last_trip_next  = trip_tenths_km;
                    last_stamp_next = now_ms[rtsm_pkg::STAMP_W-1:0];
                    pub_next        = step_ok;
                    scv_next        = base_scv || moving;
                    sc_next         = (moving && !base_scv) ? charge_percent : base_sc;
                    mv_next         = moving ? sat_add(base_mv, step) : base_mv;
                    for (int i = 0; i < rtsm_pkg::MODE_N; i++)
                    begin
                        mt_next[i] = cleared ? '0 : mt_reg[i];
                        if (moving && (mode == rtsm_pkg::MODE_W'(i)))
                        begin
                            mt_next[i] = sat_add(mt_next[i], step);
                        end
                    end
                    if (cleared)
                    begin
                        hmin_next = '0;
                        hchg_next = '0;
                        hrec_next = 1'b0;
                        for (int i = 0; i < rtsm_pkg::MODE_N; i++)
                        begin
                            hsh_next[i] = '0;
                        end
                    end
                    state_next = rtsm_pkg::S_DONE;
                    if (step_ok)
                    begin
                        hrec_next = (mv_next != '0);
                        if (scv_next)
                        begin
                            hchg_next = (sc_next > charge_percent) ?
                                        (sc_next - charge_percent) : '0;
                        end
                        if (mv_next == '0)
                        begin
                            hmin_next = '0;
                            for (int i = 0; i < rtsm_pkg::MODE_N; i++)
                            begin
                                hsh_next[i] = '0;
                            end
                        end
                        else
                        begin
                            state_next = rtsm_pkg::S_MIN_GO;
                        end
                    end
                end
            end
            rtsm_pkg::S_MIN_GO:
            begin
                div_req.start = 1'b1;
                state_next    = rtsm_pkg::S_MIN_WAIT;
            end
            rtsm_pkg::S_MIN_WAIT:
            begin
                if (div_rsp.done)
                begin
                    hmin_next  = div_rsp.quotient[rtsm_pkg::MIN_W-1:0];
                    state_next = rtsm_pkg::S_ECO_GO;
                end
            end
            rtsm_pkg::S_ECO_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = rtsm_pkg::NUM_W'(mt_reg[0])
                                   * rtsm_pkg::NUM_W'(rtsm_pkg::FULL_PERCENT) + half_mv;
                div_req.divisor  = mv_reg;
                state_next       = rtsm_pkg::S_ECO_WAIT;
            end
            rtsm_pkg::S_ECO_WAIT:
            begin
                if (div_rsp.done)
                begin
                    hsh_next[0] = div_rsp.quotient[rtsm_pkg::PCT_W-1:0];
                    state_next  = rtsm_pkg::S_NORM_GO;
                end
            end
            rtsm_pkg::S_NORM_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = rtsm_pkg::NUM_W'(mt_reg[1])
                                   * rtsm_pkg::NUM_W'(rtsm_pkg::FULL_PERCENT) + half_mv;
                div_req.divisor  = mv_reg;
                state_next       = rtsm_pkg::S_NORM_WAIT;
            end
            rtsm_pkg::S_NORM_WAIT:
            begin
                if (div_rsp.done)
                begin
                    hsh_next[1] = div_rsp.quotient[rtsm_pkg::PCT_W-1:0];
                    state_next  = rtsm_pkg::S_SPORT;
                end
            end
            rtsm_pkg::S_SPORT:
            begin
                if (share_sum > (rtsm_pkg::PCT_W + 1)'(rtsm_pkg::FULL_PERCENT))
                begin
                    hsh_next[2] = '0;
                end
                else
                begin
                    hsh_next[2] = rtsm_pkg::PCT_W'(
                        (rtsm_pkg::PCT_W + 1)'(rtsm_pkg::FULL_PERCENT) - share_sum);
                end
                state_next = rtsm_pkg::S_DONE;
            end
            rtsm_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = rtsm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rtsm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rtsm_pkg::S_IDLE;
            last_stamp_reg <= '0;
            last_trip_reg  <= '0;
            mv_reg         <= '0;
            scv_reg        <= 1'b0;
            sc_reg         <= '0;
            hmin_reg       <= '0;
            hchg_reg       <= '0;
            hrec_reg       <= 1'b0;
            pub_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < rtsm_pkg::MODE_N; i++)
            begin
                mt_reg[i]  <= '0;
                hsh_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            last_stamp_reg <= last_stamp_next;
            last_trip_reg  <= last_trip_next;
            mv_reg         <= mv_next;
            scv_reg        <= scv_next;
            sc_reg         <= sc_next;
            hmin_reg       <= hmin_next;
            hchg_reg       <= hchg_next;
            hrec_reg       <= hrec_next;
            pub_reg        <= pub_next;
            out_valid_reg  <= out_valid_next;
            for (int i = 0; i < rtsm_pkg::MODE_N; i++)
            begin
                mt_reg[i]  <= mt_next[i];
                hsh_reg[i] <= hsh_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            o_min_reg   <= hmin_reg;
            o_chg_reg   <= hchg_reg;
            o_eco_reg   <= hsh_reg[0];
            o_norm_reg  <= hsh_reg[1];
            o_sport_reg <= hsh_reg[2];
            o_rec_reg   <= hrec_reg;
            o_pub_reg   <= pub_reg;
        end
    end

    assign in_ready     = (state_reg == rtsm_pkg::S_IDLE);
    assign out_valid    = out_valid_reg;
    assign ride_minutes = o_min_reg;
    assign charge_used  = o_chg_reg;
    assign eco_share    = o_eco_reg;
    assign normal_share = o_norm_reg;
    assign sport_share  = o_sport_reg;
    assign recorded     = o_rec_reg;
    assign published    = o_pub_reg;

endmodule

FILE: sim/ride_share_checker.sv
`timescale 1ns / 1ps
// Checker for the ride time and mode share tracker: tracks max_step_ms writes, predicts each
// result word from accepted sample words and compares it field by field. Depends on rtsm_pkg.

module ride_share_checker
    import rtsm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    input  logic [PDATA_W-1:0]  prdata,
    input  logic                pready,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [31:0]         now_ms,
    input  logic [TRIP_W-1:0]   trip_tenths_km,
    input  logic [SPEED_W-1:0]  speed_kmh,
    input  logic [PCT_W-1:0]    charge_percent,
    input  logic [MODE_W-1:0]   mode,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [MIN_W-1:0]    ride_minutes,
    input  logic [PCT_W-1:0]    charge_used,
    input  logic [PCT_W-1:0]    eco_share,
    input  logic [PCT_W-1:0]    normal_share,
    input  logic [PCT_W-1:0]    sport_share,
    input  logic                recorded,
    input  logic                published,
    output int                  errors,
    output int                  pending
);

    localparam logic [63:0] STAMP_MASK = (64'd1 << TIME_W) - 64'd1;

    typedef struct packed {
        logic [MIN_W-1:0] minutes;
        logic [PCT_W-1:0] used;
        logic [PCT_W-1:0] eco;
        logic [PCT_W-1:0] normal;
        logic [PCT_W-1:0] sport;
        logic             rec;
        logic             pub;
    } ride_word_t;

    ride_word_t        due_words[$];
    int                fail_count = 0;

    logic [STEP_W-1:0] step_limit;
    logic [63:0]       stamp_seen;
    logic [TRIP_W-1:0] trip_seen;
    logic [MOV_W-1:0]  ride_ms;
    logic [MOV_W-1:0]  mode_ms[MODE_N];
    logic              start_known;
    logic [PCT_W-1:0]  start_pct;
    logic [MIN_W-1:0]  held_min;
    logic [PCT_W-1:0]  held_used;
    logic [PCT_W-1:0]  held_pct[MODE_N];
    logic              held_rec;

    function automatic logic [MOV_W-1:0] sat_add(input logic [MOV_W-1:0] a,
                                                 input logic [MOV_W-1:0] b);
        logic [MOV_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[MOV_W] ? '1 : s[MOV_W-1:0];
    endfunction

    task automatic clear_ride_totals();
        ride_ms = '0;
        start_known = 1'b0;
        start_pct = '0;
        held_min = '0;
        held_used = '0;
        held_rec = 1'b0;
        for (int i = 0; i < MODE_N; i++)
        begin
            mode_ms[i] = '0;
            held_pct[i] = '0;
        end
    endtask

    task automatic advance_ride(input logic [31:0] stamp, input logic [TRIP_W-1:0] trip,
                                input logic [SPEED_W-1:0] speed, input logic [PCT_W-1:0] charge,
                                input logic [MODE_W-1:0] md, output ride_word_t word);
        logic [63:0]      gap;
        logic [63:0]      total;
        logic [63:0]      eco;
        logic [63:0]      norm;
        logic [MOV_W-1:0] whole_min;
        if (trip < trip_seen)
            clear_ride_totals();
        trip_seen = trip;
        gap = ({32'b0, stamp} - stamp_seen) & STAMP_MASK;
        stamp_seen = {32'b0, stamp} & STAMP_MASK;
        word.pub = 1'b0;
        if (gap != 0 && gap <= {48'b0, step_limit})
        begin
            if (speed != 0)
            begin
                if (!start_known)
                begin
                    start_known = 1'b1;
                    start_pct = charge;
                end
                ride_ms = sat_add(ride_ms, gap[MOV_W-1:0]);
                if (md < MODE_N)
                    mode_ms[md] = sat_add(mode_ms[md], gap[MOV_W-1:0]);
            end
            whole_min = ride_ms / MS_PER_MINUTE;
            held_min = whole_min[MIN_W-1:0];
            held_rec = (ride_ms != 0);
            if (start_known)
                held_used = (start_pct > charge) ? start_pct - charge : '0;
            if (ride_ms == 0)
            begin
                for (int i = 0; i < MODE_N; i++)
                    held_pct[i] = '0;
            end
            else
            begin
                total = {32'b0, ride_ms};
                eco = ({32'b0, mode_ms[0]} * 64'd100 + total / 2) / total;
                norm = ({32'b0, mode_ms[1]} * 64'd100 + total / 2) / total;
                held_pct[0] = eco[PCT_W-1:0];
                held_pct[1] = norm[PCT_W-1:0];
                held_pct[2] = (eco + norm > 64'd100) ? '0 : 7'(64'd100 - eco - norm);
            end
            word.pub = 1'b1;
        end
        word.minutes = held_min;
        word.used = held_used;
        word.eco = held_pct[0];
        word.normal = held_pct[1];
        word.sport = held_pct[2];
        word.rec = held_rec;
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            fail_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ride_word_t want;
        if (!rst_n)
        begin
            clear_ride_totals();
            step_limit = MAX_STEP_RESET;
            stamp_seen = '0;
            trip_seen = '0;
            due_words.delete();
            pending <= 0;
            errors <= fail_count;
        end
        else
        begin
            if (psel && penable && pready && paddr == ADDR_MAX_STEP)
            begin
                if (pwrite)
                    step_limit = pwdata[STEP_W-1:0];
                else
                    check_field("prdata", PDATA_W'(step_limit), prdata);
            end
            if (out_valid && out_ready)
            begin
                if (due_words.size() == 0)
                begin
                    fail_count++;
                    $error("result word with no sample word waiting");
                end
                else
                begin
                    want = due_words.pop_front();
                    check_field("ride_minutes", want.minutes, ride_minutes);
                    check_field("charge_used", want.used, charge_used);
                    check_field("eco_share", want.eco, eco_share);
                    check_field("normal_share", want.normal, normal_share);
                    check_field("sport_share", want.sport, sport_share);
                    check_field("recorded", want.rec, recorded);
                    check_field("published", want.pub, published);
                end
            end
            if (in_valid && in_ready)
            begin
                advance_ride(now_ms, trip_tenths_km, speed_kmh, charge_percent, mode, want);
                due_words.push_back(want);
            end
            pending <= due_words.size();
            errors <= fail_count;
        end
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Top of the simulation: clock, reset, sample and register stimulus, result stalls and verdict.
// Depends on rtsm_pkg, ride_time_mode_share_tracker and ride_share_checker.

module testbench;
    import rtsm_pkg::*;

    localparam int          HALF_PERIOD = 4;
    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam int          PHASE_WORDS = 220;

    localparam logic [MODE_W-1:0] MODE_ECO    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_NORMAL = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SPORT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_NONE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LAST   = 3'd7;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                in_valid;
    logic                in_ready;
    logic [31:0]         now_ms;
    logic [TRIP_W-1:0]   trip_tenths_km;
    logic [SPEED_W-1:0]  speed_kmh;
    logic [PCT_W-1:0]    charge_percent;
    logic [MODE_W-1:0]   mode;
    logic                out_valid;
    logic                out_ready;
    logic [MIN_W-1:0]    ride_minutes;
    logic [PCT_W-1:0]    charge_used;
    logic [PCT_W-1:0]    eco_share;
    logic [PCT_W-1:0]    normal_share;
    logic [PCT_W-1:0]    sport_share;
    logic                recorded;
    logic                published;
    int                  errors;
    int                  pending;

    int unsigned         clock_count;
    int                  send_calm;
    int                  stall_left;
    int                  stall_calm;
    logic [STEP_W-1:0]   lim;
    logic [31:0]         cur_now;
    logic [TRIP_W-1:0]   cur_trip;
    logic [PCT_W-1:0]    cur_charge;
    logic [MODE_W-1:0]   cur_mode;

    ride_time_mode_share_tracker u_dut (.*);

    ride_share_checker u_check (.*);

    always #(HALF_PERIOD) clk = ~clk;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 20);
        return $urandom_range(30, 120);
    endfunction

    always @(posedge clk)
    begin
        clock_count <= clock_count + 1;
        if (clock_count == CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_left != 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (stall_calm != 0)
                stall_calm <= stall_calm - 1;
            else if ($urandom_range(0, 9) == 0)
            begin
                if ($urandom_range(0, 7) == 0)
                    stall_calm <= $urandom_range(50, 400);
                else
                    stall_left <= idle_len();
            end
        end
    end

    task automatic send_sample(input logic [31:0] stamp, input logic [TRIP_W-1:0] trip,
                               input logic [SPEED_W-1:0] speed, input logic [PCT_W-1:0] charge,
                               input logic [MODE_W-1:0] md);
        int gap;
        in_valid <= 1'b1;
        now_ms <= stamp;
        trip_tenths_km <= trip;
        speed_kmh <= speed;
        charge_percent <= charge;
        mode <= md;
        do
            @(posedge clk);
        while (!in_ready);
        gap = 0;
        if (send_calm != 0)
            send_calm--;
        else if ($urandom_range(0, 99) < 3)
            send_calm = $urandom_range(20, 120);
        else if ($urandom_range(0, 99) >= 45)
            gap = idle_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic ride_sample();
        int          r;
        logic [31:0] gap;
        r = $urandom_range(0, 99);
        if (r < 72)
            gap = $urandom_range(1, lim);
        else if (r < 78)
            gap = 32'(lim);
        else if (r < 86)
            gap = 0;
        else if (r < 94)
            gap = 32'(lim) + $urandom_range(1, 100);
        else
            gap = $urandom();
        cur_now = cur_now + gap;
        r = $urandom_range(0, 99);
        if (r < 2)
            cur_trip = (cur_trip == 0) ? '0 : TRIP_W'($urandom_range(0, cur_trip - 1));
        else if (r < 3)
            cur_trip = TRIP_W'($urandom_range(0, 131071));
        else if (cur_trip < 131068)
            cur_trip = cur_trip + TRIP_W'($urandom_range(0, 3));
        r = $urandom_range(0, 99);
        if (r < 4)
            cur_charge = PCT_W'($urandom_range(0, 127));
        else if (r < 12)
            cur_charge = PCT_W'($urandom_range(0, 100));
        else if (r < 40 && cur_charge != 0)
            cur_charge = cur_charge - 1;
        if ($urandom_range(0, 99) < 25)
            cur_mode = MODE_W'($urandom_range(0, 7));
        send_sample(cur_now, cur_trip,
                    ($urandom_range(0, 99) < 15) ? 8'd0 : 8'($urandom_range(1, 255)),
                    cur_charge, cur_mode);
    endtask

    task automatic apb_access(input logic wr, input logic [PDATA_W-1:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= ADDR_MAX_STEP;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain_words();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic set_limit(input logic [STEP_W-1:0] value);
        drain_words();
        repeat (4) @(posedge clk);
        apb_access(1'b1, PDATA_W'(value));
        apb_access(1'b0, '0);
        lim = value;
    endtask

    initial
    begin
        logic [STEP_W-1:0] phase_limit[5];
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        now_ms = '0;
        trip_tenths_km = '0;
        speed_kmh = '0;
        charge_percent = '0;
        mode = MODE_ECO;
        out_ready = 1'b0;
        clock_count = 0;
        send_calm = 0;
        stall_left = 0;
        stall_calm = 0;
        lim = MAX_STEP_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_sample(32'd0, 17'd0, 8'd0, 7'd100, MODE_ECO);
        send_sample(32'd100, 17'd10, 8'd0, 7'd100, MODE_ECO);
        send_sample(32'd201, 17'd20, 8'd10, 7'd90, MODE_ECO);
        send_sample(32'd300, 17'd30, 8'd255, 7'd88, MODE_NORMAL);
        send_sample(32'd1300, 17'd40, 8'd40, 7'd100, MODE_SPORT);
        send_sample(32'd3300, 17'd50, 8'd128, 7'd127, MODE_LAST);
        send_sample(32'd5301, 17'd60, 8'd20, 7'd80, MODE_ECO);
        send_sample(32'd5301, 17'd70, 8'd20, 7'd80, MODE_ECO);
        send_sample(32'd7301, 17'd131071, 8'd1, 7'd0, MODE_NONE);
        send_sample(32'd7400, 17'd0, 8'd0, 7'd50, MODE_ECO);
        send_sample(32'hFFFF_FF00, 17'd5, 8'd9, 7'd60, MODE_NORMAL);
        send_sample(32'h0000_0100, 17'd6, 8'd9, 7'd60, MODE_NORMAL);
        send_sample(32'h0000_0400, 17'd2, 8'd9, 7'd55, MODE_SPORT);
        send_sample(32'h0000_0FB8, 17'd1, 8'd5, 7'd50, MODE_SPORT);
        send_sample(32'hFFFF_FFFF, 17'd99999, 8'd200, 7'd100, MODE_LAST);
        send_sample(32'h0000_07CE, 17'd100000, 8'd30, 7'd99, MODE_ECO);

        phase_limit[0] = 16'hFFFF;
        phase_limit[1] = 16'd1;
        phase_limit[2] = STEP_W'($urandom_range(1, 65535));
        phase_limit[3] = STEP_W'($urandom_range(2, 400));
        phase_limit[4] = MAX_STEP_RESET;
        cur_trip = 17'd100000;
        cur_charge = 7'd100;
        cur_mode = MODE_ECO;
        for (int p = 0; p < 5; p++)
        begin
            set_limit(phase_limit[p]);
            cur_now = $urandom();
            for (int i = 0; i < PHASE_WORDS; i++)
                ride_sample();
        end

        drain_words();
        repeat (150) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
